// File: rtl/mbrtu_pkg.sv
// Package: shared types and constants for the Modbus RTU master.
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;
    localparam logic [1:0] MODE_RD    = 2'd0;
    localparam logic [1:0] MODE_WR    = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;
    localparam logic [1:0] MODE_TOUT  = 2'd3;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_STAT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ARG     = 3'd1;
    localparam logic [2:0] ST_TOUT    = 3'd2;
    localparam logic [2:0] ST_PROTO   = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_EXC     = 3'd5;

    localparam logic [7:0] FN_READ    = 8'h03;
    localparam logic [7:0] FN_WRITE   = 8'h06;
    localparam logic [7:0] FN_EXC_BIT = 8'h80;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int unsigned BUF_DEPTH = 32;

    localparam logic [1:0] REG_SLAVE_ID = 2'd0;
    localparam logic [1:0] REG_MAX_ATT  = 2'd1;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] reg_word;
        logic [4:0]  word_index;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] reg_addr;
        logic [15:0] count_or_value;
        logic [7:0]  rx_byte;
    } t_in;

    // Controller to datapath commands.
    typedef struct packed {
        logic       start;       // latch request fields, load attempts
        logic       frame_init;  // clear reply state, reset crc
        logic       crc_clr;     // reset crc for request build
        logic       crc_feed;    // fold crc_byte into crc
        logic [7:0] crc_byte;
        logic       rx_take;     // register a reply byte
        logic       att_dec;
        logic [4:0] rd_addr;     // buffer read address
    } t_cmd;

    typedef struct packed {
        logic        is_write;
        logic [15:0] addr;
        logic [15:0] operand;
        logic [15:0] crc;
        logic [15:0] tail;
        logic [7:0]  func;
        logic [7:0]  third;
        logic        mism;
        logic        echo_bad;
        logic [6:0]  bcnt;
        logic [7:0]  att;
        logic [15:0] rd_data;
    } t_sts;

    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction
endpackage
`default_nettype wire

// File: rtl/mbrtu_if.sv
// Interface: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps
`default_nettype none
interface mbrtu_if #(parameter int unsigned W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/mbrtu_dp.sv
// Datapath: request fields, reply checks, CRC and word buffer.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mbrtu_pkg::t_in   i_in,
    input  wire logic [7:0]       i_slave_id,
    input  wire logic [7:0]       i_max_att,
    input  wire mbrtu_pkg::t_cmd  i_cmd,
    output mbrtu_pkg::t_sts       o_sts
);
    logic        r_is_write;
    logic [15:0] r_addr, r_oper, r_crc, r_tail;
    logic [7:0]  r_func, r_third, r_hold, r_att;
    logic        r_mism, r_echo;
    logic [6:0]  r_bcnt;
    logic [15:0] r_mem [mbrtu_pkg::BUF_DEPTH];
    logic [15:0] r_rd;

    logic [7:0] b;
    logic [6:0] idx;
    logic       exc;
    logic [7:0] want;
    logic [6:0] data_end;
    logic [6:0] k;
    assign b = i_in.rx_byte;
    assign idx = r_bcnt;
    assign data_end = 7'd3 + r_third[6:0];
    assign k = idx - 7'd3;
    always_comb begin
        case (idx[1:0])
            2'd2: want = r_addr[15:8];
            2'd3: want = r_addr[7:0];
            2'd0: want = r_oper[15:8];
            default: want = r_oper[7:0];
        endcase
    end
    // write reply: exception judged on function byte, current byte when idx==1
    assign exc = ((idx == 7'd1) ? b : r_func) == (mbrtu_pkg::FN_WRITE | mbrtu_pkg::FN_EXC_BIT);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_cmd.rd_addr];
        if (!i_rst_n) begin
            r_is_write <= 1'b0; r_addr <= '0; r_oper <= '0;
            r_crc <= mbrtu_pkg::CRC_INIT; r_tail <= '0; r_func <= '0;
            r_third <= '0; r_hold <= '0; r_mism <= 1'b0; r_echo <= 1'b0;
            r_bcnt <= '0; r_att <= '0;
        end else begin
            if (i_cmd.start) begin
                r_is_write <= (i_in.mode == mbrtu_pkg::MODE_WR);
                r_addr <= i_in.reg_addr;
                r_oper <= i_in.count_or_value;
                r_att <= (i_max_att == 8'd0) ? 8'd1 : i_max_att;
            end
            if (i_cmd.att_dec && r_att != 8'd0) r_att <= r_att - 8'd1;
            if (i_cmd.crc_clr) r_crc <= mbrtu_pkg::CRC_INIT;
            if (i_cmd.crc_feed) r_crc <= mbrtu_pkg::crc_add(r_crc, i_cmd.crc_byte);
            if (i_cmd.frame_init) begin
                r_bcnt <= '0; r_crc <= mbrtu_pkg::CRC_INIT; r_tail <= '0;
                r_func <= '0; r_third <= '0; r_mism <= 1'b0; r_echo <= 1'b0;
                r_hold <= '0;
            end
            if (i_cmd.rx_take) begin
                r_bcnt <= r_bcnt + 7'd1;
                if (r_is_write) begin
                    if (idx == 7'd0) r_mism <= (b != i_slave_id);
                    if (idx == 7'd1) r_func <= b;
                    if (idx == 7'd2) r_third <= b;
                    if (idx < 7'd3 || (!exc && idx < 7'd6))
                        r_crc <= mbrtu_pkg::crc_add(r_crc, b);
                    if (idx >= 7'd2 && idx <= 7'd5 && b != want) r_echo <= 1'b1;
                    if ((exc && idx == 7'd3) || (!exc && idx == 7'd6))
                        r_tail <= {8'h00, b};
                    else if ((exc && idx == 7'd4) || (!exc && idx == 7'd7))
                        r_tail <= r_tail | {b, 8'h00};
                end else if (idx < 7'd3) begin
                    r_crc <= mbrtu_pkg::crc_add(r_crc, b);
                    if (idx == 7'd0) r_mism <= (b != i_slave_id);
                    if (idx == 7'd1) r_func <= b;
                    if (idx == 7'd2) r_third <= b;
                end else if (r_func == (mbrtu_pkg::FN_READ | mbrtu_pkg::FN_EXC_BIT)) begin
                    if (idx == 7'd3) r_tail <= {8'h00, b};
                    else r_tail <= r_tail | {b, 8'h00};
                end else if (idx < data_end) begin
                    r_crc <= mbrtu_pkg::crc_add(r_crc, b);
                    if (!k[0]) r_hold <= b;
                    else r_mem[k[5:1]] <= {r_hold, b};
                end else if (idx == data_end) begin
                    r_tail <= {8'h00, b};
                end else begin
                    r_tail <= r_tail | {b, 8'h00};
                end
            end
        end
    end

    assign o_sts = '{is_write: r_is_write, addr: r_addr, operand: r_oper, crc: r_crc,
                     tail: r_tail, func: r_func, third: r_third, mism: r_mism,
                     echo_bad: r_echo, bcnt: r_bcnt, att: r_att, rd_data: r_rd};
endmodule
`default_nettype wire

// File: rtl/mbrtu_ctrl.sv
// Controller: sequences request emission, reply judgement, retries and word burst.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire mbrtu_pkg::t_in   i_in,
    input  wire logic [7:0]       i_slave_id,
    input  wire mbrtu_pkg::t_sts  i_sts,
    output mbrtu_pkg::t_cmd       o_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output mbrtu_pkg::t_out       o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_TXCRC, S_TX, S_RD_HEAD, S_RD_EXC, S_RD_BODY, S_WR_RESP,
        S_JUDGE, S_FAIL, S_BURST, S_BURST_W, S_FINAL, S_OUT
    } t_state;

    t_state r_state, n_ret;
    t_state r_ret;            // state after a result word is taken
    t_state r_wait;           // reply phase to return to
    logic [3:0] r_cnt;        // request byte position
    logic [5:0] r_widx;
    logic [2:0] r_fail_st;
    mbrtu_pkg::t_out r_out;
    logic r_ov;

    logic [7:0] fbyte;
    logic [2:0] bi;
    logic       phase_busy;
    logic       is_exc;

    function automatic mbrtu_pkg::t_out mk_out(input logic [1:0] kind, input logic [7:0] tx,
                                               input logic [15:0] w, input logic [4:0] wi,
                                               input logic [2:0] st, input logic [7:0] ex,
                                               input logic lst);
        mk_out = '{kind: kind, tx_byte: tx, reg_word: w, word_index: wi, status: st,
                   exception_code: ex, last: lst};
    endfunction

    assign bi = r_cnt[2:0];
    always_comb begin
        case (bi)
            3'd0: fbyte = i_slave_id;
            3'd1: fbyte = i_sts.is_write ? mbrtu_pkg::FN_WRITE : mbrtu_pkg::FN_READ;
            3'd2: fbyte = i_sts.addr[15:8];
            3'd3: fbyte = i_sts.addr[7:0];
            3'd4: fbyte = i_sts.operand[15:8];
            3'd5: fbyte = i_sts.operand[7:0];
            3'd6: fbyte = i_sts.crc[7:0];
            default: fbyte = i_sts.crc[15:8];
        endcase
    end
    assign phase_busy = (r_state == S_RD_HEAD) || (r_state == S_RD_EXC) ||
                        (r_state == S_RD_BODY) || (r_state == S_WR_RESP);
    // exception replies carry the high bit in the function byte
    assign is_exc = (i_sts.func & mbrtu_pkg::FN_EXC_BIT) != 8'h00;
    assign o_in_ready = (r_state == S_IDLE) || phase_busy;
    assign o_out_valid = r_ov;
    assign o_out = r_out;
    assign n_ret = r_ret;

    logic acc;
    assign acc = i_in_valid && o_in_ready;
    logic [5:0] cnt_lim;
    assign cnt_lim = (i_sts.operand > 16'(mbrtu_pkg::BUF_DEPTH)) ? 6'd32 : i_sts.operand[5:0];

    always_comb begin
        o_cmd = '0;
        o_cmd.crc_byte = fbyte;
        o_cmd.rd_addr = r_widx[4:0];
        if (r_state == S_IDLE && acc && i_in.mode <= mbrtu_pkg::MODE_WR &&
            !(i_in.mode == mbrtu_pkg::MODE_RD && (i_in.count_or_value == 16'd0 ||
              i_in.count_or_value > 16'(mbrtu_pkg::BUF_DEPTH))))
            o_cmd.start = 1'b1;
        if (r_state == S_TXCRC) begin
            if (r_cnt == 4'd0) o_cmd.crc_clr = 1'b1;
            else o_cmd.crc_feed = 1'b1;
            o_cmd.crc_byte = (r_cnt == 4'd0) ? 8'h00 : r_out.tx_byte;
        end
        if (phase_busy && acc && i_in.mode == mbrtu_pkg::MODE_BYTE) o_cmd.rx_take = 1'b1;
        if (r_state == S_FAIL) o_cmd.att_dec = 1'b1;
        if (r_state == S_TX && r_cnt == 4'd8) o_cmd.frame_init = 1'b1;
    end

    // Request build: S_TXCRC folds bytes 0..5 (cnt 1..6 fold previous), then S_TX emits 8.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE; r_wait <= S_IDLE; r_cnt <= '0;
            r_widx <= '0; r_fail_st <= '0; r_ov <= 1'b0; r_out <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (acc && i_in.mode <= mbrtu_pkg::MODE_WR) begin
                    if (o_cmd.start) begin
                        r_state <= S_TXCRC; r_cnt <= '0;
                    end else begin
                        r_out <= mk_out(mbrtu_pkg::KIND_STAT, 8'h00, 16'h0000, 5'd0,
                                        mbrtu_pkg::ST_ARG, 8'h00, 1'b1);
                        r_ov <= 1'b1; r_state <= S_OUT; r_ret <= S_IDLE;
                    end
                end
                S_TXCRC: begin
                    r_out.tx_byte <= fbyte;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd6) begin
                        r_state <= S_TX; r_cnt <= '0;
                    end
                end
                S_TX: begin
                    if (r_cnt == 4'd8) begin
                        r_state <= i_sts.is_write ? S_WR_RESP : S_RD_HEAD;
                    end else begin
                        r_out <= mk_out(mbrtu_pkg::KIND_TX, fbyte, 16'h0000, 5'd0,
                                        mbrtu_pkg::ST_OK, 8'h00, r_cnt == 4'd7);
                        r_ov <= 1'b1; r_state <= S_OUT; r_ret <= S_TX;
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_RD_HEAD, S_RD_EXC, S_RD_BODY, S_WR_RESP: if (acc) begin
                    if (i_in.mode == mbrtu_pkg::MODE_TOUT) begin
                        r_fail_st <= mbrtu_pkg::ST_TOUT; r_state <= S_FAIL;
                    end else if (i_in.mode == mbrtu_pkg::MODE_BYTE) begin
                        r_wait <= r_state; r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    // bcnt now counts bytes taken; last index is bcnt-1
                    r_state <= r_wait;
                    if (r_wait == S_WR_RESP) begin
                        if (i_sts.bcnt == 7'd8) begin
                            if (i_sts.mism) begin
                                r_fail_st <= mbrtu_pkg::ST_PROTO; r_state <= S_FAIL;
                            end else if (i_sts.func == (mbrtu_pkg::FN_WRITE | mbrtu_pkg::FN_EXC_BIT)) begin
                                if (i_sts.crc != i_sts.tail) begin
                                    r_fail_st <= mbrtu_pkg::ST_CRC; r_state <= S_FAIL;
                                end else r_state <= S_FINAL;
                            end else if (i_sts.func != mbrtu_pkg::FN_WRITE || i_sts.echo_bad) begin
                                r_fail_st <= (i_sts.func != mbrtu_pkg::FN_WRITE ||
                                              i_sts.crc == i_sts.tail) ? mbrtu_pkg::ST_PROTO
                                                                        : mbrtu_pkg::ST_CRC;
                                r_state <= S_FAIL;
                            end else if (i_sts.crc != i_sts.tail) begin
                                r_fail_st <= mbrtu_pkg::ST_CRC; r_state <= S_FAIL;
                            end else r_state <= S_FINAL;
                        end
                    end else if (r_wait == S_RD_HEAD) begin
                        if (i_sts.bcnt == 7'd3) begin
                            if (i_sts.mism || (i_sts.func != (mbrtu_pkg::FN_READ | mbrtu_pkg::FN_EXC_BIT) &&
                                (i_sts.func != mbrtu_pkg::FN_READ ||
                                 i_sts.third != {i_sts.operand[6:0], 1'b0}))) begin
                                r_fail_st <= mbrtu_pkg::ST_PROTO; r_state <= S_FAIL;
                            end else if (i_sts.func != mbrtu_pkg::FN_READ) r_state <= S_RD_EXC;
                            else r_state <= S_RD_BODY;
                        end
                    end else if (r_wait == S_RD_EXC) begin
                        if (i_sts.bcnt == 7'd5) begin
                            if (i_sts.crc != i_sts.tail) begin
                                r_fail_st <= mbrtu_pkg::ST_CRC; r_state <= S_FAIL;
                            end else r_state <= S_FINAL;
                        end
                    end else begin
                        if (i_sts.bcnt == 7'd5 + i_sts.third[6:0]) begin
                            if (i_sts.crc != i_sts.tail) begin
                                r_fail_st <= mbrtu_pkg::ST_CRC; r_state <= S_FAIL;
                            end else begin
                                r_widx <= '0; r_state <= S_BURST;
                            end
                        end
                    end
                end
                S_FAIL: begin
                    if (i_sts.att > 8'd1) begin
                        r_state <= S_TXCRC; r_cnt <= '0;
                    end else begin
                        r_out <= mk_out(mbrtu_pkg::KIND_STAT, 8'h00, 16'h0000, 5'd0,
                                        r_fail_st, 8'h00, 1'b1);
                        r_ov <= 1'b1; r_state <= S_OUT; r_ret <= S_IDLE;
                    end
                end
                S_BURST: begin
                    // read address presented; data is registered next cycle
                    if (r_widx == cnt_lim) r_state <= S_FINAL;
                    else r_state <= S_BURST_W;
                end
                S_BURST_W: begin
                    r_out <= mk_out(mbrtu_pkg::KIND_WORD, 8'h00, i_sts.rd_data, r_widx[4:0],
                                    mbrtu_pkg::ST_OK, 8'h00, 1'b0);
                    r_ov <= 1'b1; r_state <= S_OUT; r_ret <= S_BURST;
                    r_widx <= r_widx + 6'd1;
                end
                S_FINAL: begin
                    r_out <= mk_out(mbrtu_pkg::KIND_STAT, 8'h00, 16'h0000, 5'd0,
                                    is_exc ? mbrtu_pkg::ST_EXC : mbrtu_pkg::ST_OK,
                                    is_exc ? i_sts.third : 8'h00, 1'b1);
                    r_ov <= 1'b1; r_state <= S_OUT; r_ret <= S_IDLE;
                end
                S_OUT: if (i_out_ready) begin
                    r_ov <= 1'b0; r_state <= n_ret;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/modbus_rtu_master_transaction.sv
// Top level: Modbus RTU master transaction engine.
`timescale 1ns / 1ps
`default_nettype none
// Modbus RTU master, one transaction at a time. A start word (read holding
// registers or write single register) emits an 8-byte request with CRC-16;
// received bytes and timeout words then drive reply checking, retries and
// the final status. Read words are held in a 32-entry buffer and released
// only after the reply CRC passes. A start first builds the CRC over the
// request bytes, then each request byte is emitted and waits for the output
// handoff; each received byte is accepted and then judged in the
// controller; each buffered word passes the buffer read port and then the
// output handoff. One word is worked at a time. Configuration: i_cfg_we,
// index 0 slave id, index 1 max attempts (0 acts as 1).
module modbus_rtu_master_transaction #(
    parameter int unsigned MAX_READ_REGS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    mbrtu_if.sink            in_ch,
    mbrtu_if.source          out_ch
);
    logic [7:0] r_slave_id, r_max_att;
    mbrtu_pkg::t_in  in_w;
    mbrtu_pkg::t_cmd cmd;
    mbrtu_pkg::t_sts sts;
    mbrtu_pkg::t_out out_w;
    mbrtu_pkg::t_in  in_gated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id <= 8'd1;
            r_max_att  <= 8'd3;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mbrtu_pkg::REG_SLAVE_ID[0:0]) r_slave_id <= i_cfg_data;
            else r_max_att <= i_cfg_data;
        end
    end

    assign in_w = in_ch.data;
    // reads beyond the parameter limit are rejected like an empty read
    always_comb begin
        in_gated = in_w;
        if (in_w.mode == mbrtu_pkg::MODE_RD && in_w.count_or_value > 16'(MAX_READ_REGS))
            in_gated.count_or_value = 16'd0;
    end

    mbrtu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_in(in_gated), .i_slave_id(r_slave_id), .i_sts(sts), .o_cmd(cmd),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .o_out(out_w)
    );
    mbrtu_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_w), .i_slave_id(r_slave_id),
        .i_max_att(r_max_att), .i_cmd(cmd), .o_sts(sts)
    );
    assign out_ch.data = out_w;

`ifndef SYNTHESIS
    a_last_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_w.kind == mbrtu_pkg::KIND_STAT |-> out_w.last)
        else $error("status word without last");
    a_word_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_w.kind == mbrtu_pkg::KIND_WORD |-> !out_w.last)
        else $error("register word marked last");
`endif
endmodule
`default_nettype wire
